[design/cca_pkg.sv]
// Package for the cluster centroid accumulator: field widths, sum widths,
// count and divider widths, and stream command codes. No dependencies.
`timescale 1ns / 1ps
package cca_pkg;
  localparam int LW = 15;
  localparam int CW = 16;
  localparam int RW = 11;
  localparam int LSUM_W = 37;
  localparam int CSUM_W = 38;
  localparam int RSUM_W = 33;
  localparam int CNT_W = 23;
  localparam int DIV_W = 39;
  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_FIN = 1'b1;
endpackage

[design/cca_divider.sv]
// Restoring divider, one quotient bit per cycle, for rounded means.
// Depends on cca_pkg.
`timescale 1ns / 1ps
module cca_divider
  import cca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] numer,
  input  logic [CNT_W:0]   denom,
  output logic             done,
  output logic [DIV_W-1:0] quot
);
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] num_sh;
  logic [5:0]       bit_cnt;
  logic             busy;
  logic [DIV_W:0]   trial;

  assign trial = {rem, num_sh[DIV_W-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      rem     <= '0;
      num_sh  <= numer;
      quot    <= '0;
      bit_cnt <= 6'(DIV_W);
    end else if (busy) begin
      num_sh <= num_sh << 1;
      if (trial >= (DIV_W+1)'(denom)) begin
        rem  <= DIV_W'(trial - (DIV_W+1)'(denom));
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
      bit_cnt <= bit_cnt - 6'd1;
      if (bit_cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

[design/cluster_centroid_accumulator.sv]
// Top level of the cluster centroid accumulator: per-cluster sum memory,
// read-modify-write accumulate path, and finalize walk. Depends on cca_pkg
// and cca_divider.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: label,l,a,b,row,col; tuser: cmd,labelled
//  m_axis  | out | m_axis_tvalid/tready   | tdata: index,empty,l,a,b,row,col; tlast
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_data: num_clusters
//
// Accumulate: a pixel's cluster entry is read from memory, the pixel is added,
// and the sum is written back. Finalize: per active cluster, the entry is read,
// then five divisions run on the shared divider (skipped for an empty cluster),
// then the result goes to the output; then a clearing sweep of all MAX_CLUSTERS
// entries. After reset the same sweep runs before the first pixel is taken.
// A stalled output holds the walk; input is taken only when idle.
`timescale 1ns / 1ps
module cluster_centroid_accumulator
  import cca_pkg::*;
#(
  parameter int MAX_CLUSTERS = 64,
  parameter int MAX_ROWS     = 2048,
  parameter int MAX_COLS     = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: label[5:0], l_value[20:6], a_value[36:21], b_value[52:37],
  // row[63:53], col[74:64], zero fill to 80
  input  logic [79:0] s_axis_tdata,
  // tuser: cmd[0], labelled[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cluster_index[5:0], empty_res[6], l_mean[21:7], a_mean[37:22],
  // b_mean[53:38], row_mean[64:54], col_mean[75:65], zero fill to 80
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  typedef struct packed {
    logic [LSUM_W-1:0] ls;
    logic [CSUM_W-1:0] as;
    logic [CSUM_W-1:0] bs;
    logic [RSUM_W-1:0] rs;
    logic [RSUM_W-1:0] cs;
    logic [CNT_W-1:0]  n;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_AWR, S_FRD, S_FLOAD, S_DIV, S_DWAIT, S_OUT
  } state_t;

  state_t state;
  entry_t mem [MAX_CLUSTERS];
  entry_t rd_q;
  entry_t wr_d;
  logic [AW-1:0] addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [6:0]    num_clusters;
  logic [6:0]    active;
  logic [AW:0]   k;
  logic [2:0]    fld;

  // captured pixel
  logic [LW-1:0] px_l;
  logic [CW-1:0] px_a, px_b;
  logic [RW-1:0] px_r, px_c;

  // divider
  logic             dv_start, dv_done;
  logic [DIV_W-1:0] dv_num, dv_q;
  logic [CNT_W:0]   dv_den;
  logic             dv_neg;
  logic [DIV_W-1:0] mag;

  logic [LW-1:0] l_mean;
  logic [CW-1:0] a_mean, b_mean;
  logic [RW-1:0] row_mean, col_mean;

  assign active = (num_clusters > 7'(MAX_CLUSTERS)) ? 7'(MAX_CLUSTERS) : num_clusters;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  cca_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .numer(dv_num), .denom(dv_den),
    .done(dv_done), .quot(dv_q)
  );

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_d;
    rd_q <= mem[addr];
  end

  // pick the signed magnitude of the field being divided
  always_comb begin
    logic [CSUM_W-1:0] s;
    logic [CSUM_W-1:0] s_neg;
    s = '0;
    s_neg = '0;
    mag = '0;
    dv_neg = 1'b0;
    case (fld)
      3'd0: mag = DIV_W'(rd_q.ls);
      3'd1, 3'd2: begin
        s = (fld == 3'd1) ? rd_q.as : rd_q.bs;
        s_neg = ~s + 1'b1;
        dv_neg = s[CSUM_W-1];
        mag = dv_neg ? DIV_W'(s_neg) : DIV_W'(s);
        if (dv_neg && mag == '0) mag = DIV_W'(1) << (CSUM_W-1);
      end
      3'd3: mag = DIV_W'(rd_q.rs);
      3'd4: mag = DIV_W'(rd_q.cs);
      default: mag = '0;
    endcase
  end
  assign dv_num = (mag << 1) + DIV_W'(rd_q.n);
  assign dv_den = {rd_q.n, 1'b0};

  always_ff @(posedge clk) begin
    wr_en    <= 1'b0;
    dv_start <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      k <= '0;
      addr <= '0;
      num_clusters <= 7'd64;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) num_clusters <= cfg_data;
      case (state)
        S_CLEAR: begin
          wr_en   <= 1'b1;
          wr_addr <= k[AW-1:0];
          wr_d    <= '0;
          if (k == (AW+1)'(MAX_CLUSTERS-1)) state <= S_IDLE;
          k <= k + 1'b1;
        end
        S_IDLE: begin
          k <= '0;
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0] == CMD_FIN) begin
              addr  <= '0;
              state <= (active == 7'd0) ? S_CLEAR : S_FRD;
            end else if (s_axis_tuser[1] && 7'(s_axis_tdata[5:0]) < active
                         && 32'(s_axis_tdata[63:53]) < MAX_ROWS
                         && 32'(s_axis_tdata[74:64]) < MAX_COLS) begin
              addr  <= s_axis_tdata[AW-1:0];
              px_l  <= s_axis_tdata[20:6];
              px_a  <= s_axis_tdata[36:21];
              px_b  <= s_axis_tdata[52:37];
              px_r  <= s_axis_tdata[63:53];
              px_c  <= s_axis_tdata[74:64];
              state <= S_ARD;
            end
          end
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          wr_en   <= 1'b1;
          wr_addr <= addr;
          wr_d.ls <= rd_q.ls + LSUM_W'(px_l);
          wr_d.as <= rd_q.as + CSUM_W'($signed(px_a));
          wr_d.bs <= rd_q.bs + CSUM_W'($signed(px_b));
          wr_d.rs <= rd_q.rs + RSUM_W'(px_r);
          wr_d.cs <= rd_q.cs + RSUM_W'(px_c);
          wr_d.n  <= rd_q.n + 1'b1;
          state   <= S_IDLE;
        end
        S_FRD: begin
          fld   <= '0;
          state <= S_FLOAD;
        end
        S_FLOAD: begin
          l_mean <= '0; a_mean <= '0; b_mean <= '0; row_mean <= '0; col_mean <= '0;
          if (rd_q.n == '0) state <= S_OUT;
          else begin
            dv_start <= 1'b1;
            state    <= S_DIV;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (dv_done) begin
            case (fld)
              3'd0: l_mean <= (dv_q > DIV_W'(2**LW-1)) ? '1 : dv_q[LW-1:0];
              3'd1, 3'd2: begin
                logic [CW-1:0] v;
                if (dv_neg) v = (dv_q > DIV_W'(32768)) ? 16'h8000 : CW'(-dv_q);
                else        v = (dv_q > DIV_W'(32767)) ? 16'h7fff : dv_q[CW-1:0];
                if (fld == 3'd1) a_mean <= v; else b_mean <= v;
              end
              3'd3: row_mean <= (dv_q > DIV_W'(2**RW-1)) ? '1 : dv_q[RW-1:0];
              default: col_mean <= (dv_q > DIV_W'(2**RW-1)) ? '1 : dv_q[RW-1:0];
            endcase
            if (fld == 3'd4) state <= S_OUT;
            else begin
              fld      <= fld + 3'd1;
              dv_start <= 1'b1;
              state    <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= ((k + 1'b1) == (AW+1)'(active));
            m_axis_tdata  <= {4'd0, col_mean, row_mean, b_mean, a_mean, l_mean,
                              (rd_q.n == '0), 6'(k)};
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if ((k + 1'b1) == (AW+1)'(active)) begin
              k <= '0;
              state <= S_CLEAR;
            end else begin
              k <= k + 1'b1;
              addr <= AW'(k + 1'b1);
              state <= S_FRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken during walk");
  a_tlast_tv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == 6'(active - 7'd1))
    else $error("tlast on wrong cluster");
  a_wr_after: assert property (@(posedge clk) disable iff (rst)
    state == S_AWR |=> wr_en) else $error("missing write back");
`endif
endmodule
